FILE: rtl/core/bhc_pkg.sv
// ----------------------------------------------------------------------------
// bhc_pkg
// Shared types and constants of the bigram hash counter: field widths, table
// geometry, the delimiter code list and the records passed between stages.
// ----------------------------------------------------------------------------
`default_nettype none

package bhc_pkg;

   localparam int SLOTS       = 4096;
   localparam int WAYS        = 4;
   localparam int BUCKET_W    = 12;
   localparam int WAY_W       = 2;
   localparam int CHAR_W      = 21;
   localparam int COUNT_W     = 32;
   localparam int NUM_PUNCT   = 20;
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_AW    = 1;

   typedef logic [CHAR_W-1:0]   char_type;
   typedef logic [COUNT_W-1:0]  count_type;
   typedef logic [BUCKET_W-1:0] bucket_type;
   typedef logic [WAY_W-1:0]    way_type;

   localparam char_type DELIM_MAX = char_type'(128);
   localparam count_type COUNT_MAX = '1;

   localparam char_type PUNCT_CODES [NUM_PUNCT] = '{
      char_type'(183),   char_type'(12288), char_type'(12289), char_type'(12290),
      char_type'(12300), char_type'(12301), char_type'(12302), char_type'(12303),
      char_type'(12304), char_type'(12305), char_type'(12308), char_type'(12309),
      char_type'(65281), char_type'(65288), char_type'(65289), char_type'(65292),
      char_type'(65295), char_type'(65306), char_type'(65307), char_type'(65311)
   };

   typedef enum logic {
      OP_FEED = 1'b0,
      OP_READ = 1'b1
   } opcode_type;

   // Classified transaction passed from the front end to the table engine.
   typedef struct packed {
      opcode_type opcode;
      logic       is_delimiter;
      logic       pair_formed;
      char_type   first_char;
      char_type   second_char;
      bucket_type bucket;
      way_type    way;
      count_type  total;
   } cmd_type;

   typedef struct packed {
      logic      valid;
      char_type  first_char;
      char_type  second_char;
      count_type count;
   } way_entry_type;

   typedef way_entry_type [WAYS-1:0] row_type;

   typedef struct packed {
      logic      pair_formed;
      logic      is_delimiter;
      logic      dropped;
      logic      entry_valid;
      char_type  first_char;
      char_type  second_char;
      count_type pair_count;
      count_type total_pairs;
   } result_type;

   typedef struct packed {
      logic    full;
      logic    empty;
      cmd_type head;
   } queue_status_type;

endpackage

`default_nettype wire

FILE: rtl/core/bhc_if.sv
// ----------------------------------------------------------------------------
// bhc_if
// Valid/ready channel interfaces for the request and response streams.
// ----------------------------------------------------------------------------
`default_nettype none

interface bhc_req_if import bhc_pkg::*; ();
   logic       valid;
   logic       ready;
   opcode_type opcode;
   char_type   char_code;
   bucket_type read_bucket;
   way_type    read_way;

   modport source (output valid, output opcode, output char_code,
                   output read_bucket, output read_way, input ready);
   modport sink   (input valid, input opcode, input char_code,
                   input read_bucket, input read_way, output ready);
endinterface

interface bhc_rsp_if import bhc_pkg::*; ();
   logic      valid;
   logic      ready;
   logic      pair_formed;
   logic      is_delimiter;
   logic      dropped;
   logic      entry_valid;
   char_type  first_char;
   char_type  second_char;
   count_type pair_count;
   count_type total_pairs;

   modport source (output valid, output pair_formed, output is_delimiter,
                   output dropped, output entry_valid, output first_char,
                   output second_char, output pair_count, output total_pairs,
                   input ready);
   modport sink   (input valid, input pair_formed, input is_delimiter,
                   input dropped, input entry_valid, input first_char,
                   input second_char, input pair_count, input total_pairs,
                   output ready);
endinterface

`default_nettype wire

FILE: rtl/core/bhc_front.sv
// ----------------------------------------------------------------------------
// bhc_front
// Accepts requests, classifies characters as delimiters, tracks the previous
// character and the running bigram total, and hashes each bigram to a bucket.
// ----------------------------------------------------------------------------
`default_nettype none

module bhc_front import bhc_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   bhc_req_if.sink          req_bus,
   input  logic             clear_done,
   input  queue_status_type q_status,
   output logic             push,
   output cmd_type          push_cmd
);

   char_type  prev_ff, prev_in;
   count_type total_ff, total_in;
   logic      delim;
   logic      accept;

   always_comb begin
      delim = (req_bus.char_code <= DELIM_MAX);
      for (int i = 0; i < NUM_PUNCT; i++) begin
         if (req_bus.char_code == PUNCT_CODES[i]) begin
            delim = 1'b1;
         end
      end
   end

   assign req_bus.ready = clear_done && !q_status.full;
   assign accept        = req_bus.valid && req_bus.ready;
   assign push          = accept;

   always_comb begin
      prev_in  = prev_ff;
      total_in = total_ff;
      push_cmd              = '0;
      push_cmd.opcode       = req_bus.opcode;
      push_cmd.bucket       = req_bus.read_bucket;
      push_cmd.way          = req_bus.read_way;
      if (req_bus.opcode == OP_FEED) begin
         priority if (delim) begin
            push_cmd.is_delimiter = 1'b1;
            prev_in               = '0;
         end else if (prev_ff == '0) begin
            prev_in = req_bus.char_code;
         end else begin
            push_cmd.pair_formed = 1'b1;
            push_cmd.first_char  = prev_ff;
            push_cmd.second_char = req_bus.char_code;
            // The bucket count is a power of two, so the modulo is a truncation.
            push_cmd.bucket = bucket_type'({prev_ff, 5'b0} + {5'b0, prev_ff}
                                           + {5'b0, req_bus.char_code});
            prev_in = req_bus.char_code;
            if (total_ff != COUNT_MAX) begin
               total_in = total_ff + count_type'(1);
            end
         end
      end
      push_cmd.total = total_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff  <= '0;
         total_ff <= '0;
      end else if (accept) begin
         prev_ff  <= prev_in;
         total_ff <= total_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/core/bhc_queue.sv
// ----------------------------------------------------------------------------
// bhc_queue
// Two-entry queue of classified transactions between front end and engine.
// ----------------------------------------------------------------------------
`default_nettype none

module bhc_queue import bhc_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  cmd_type          push_cmd,
   input  logic             pop,
   output queue_status_type q_status
);

   cmd_type               entries_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]     count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QUEUE_AW'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + QUEUE_AW'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + (QUEUE_AW+1)'(1);
      end else if (pop && !push) begin
         count_in = count_ff - (QUEUE_AW+1)'(1);
      end
   end

   assign q_status.full  = (count_ff == (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign q_status.empty = (count_ff == '0);
   assign q_status.head  = entries_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/core/bhc_back.sv
// ----------------------------------------------------------------------------
// bhc_back
// Table engine: clears the bucket memory after reset, then for each
// transaction reads one bucket row, compares its ways, writes the row back
// when a pair is counted or added, and registers the response.
// ----------------------------------------------------------------------------
`default_nettype none

module bhc_back import bhc_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  queue_status_type q_status,
   output logic             pop,
   output logic             clear_done,
   bhc_rsp_if.source        rsp_bus
);

   typedef enum logic [2:0] {
      BK_CLEAR  = 3'b001,
      BK_IDLE   = 3'b010,
      BK_LOOKUP = 3'b100
   } back_state_type;

   back_state_type state_ff, state_in;
   bucket_type     clear_addr_ff, clear_addr_in;
   cmd_type        cmd_ff, cmd_in;
   row_type        rd_row_ff;
   logic           out_valid_ff, out_valid_in;
   result_type     out_ff, out_in;

   row_type        row_mem [SLOTS];
   logic           rd_en;
   bucket_type     rd_addr;
   logic           wr_en;
   bucket_type     wr_addr;
   row_type        wr_row;

   logic           hit_found, free_found;
   way_type        hit_way, free_way;
   count_type      hit_count;
   way_entry_type  read_entry;

   always_comb begin
      hit_found  = 1'b0;
      free_found = 1'b0;
      hit_way    = '0;
      free_way   = '0;
      for (int w = 0; w < WAYS; w++) begin
         if (rd_row_ff[w].valid) begin
            if (!hit_found && rd_row_ff[w].first_char == cmd_ff.first_char
                && rd_row_ff[w].second_char == cmd_ff.second_char) begin
               hit_found = 1'b1;
               hit_way   = WAY_W'(w);
            end
         end else if (!free_found) begin
            free_found = 1'b1;
            free_way   = WAY_W'(w);
         end
      end
      hit_count = rd_row_ff[hit_way].count;
      if (hit_count != COUNT_MAX) begin
         hit_count = hit_count + count_type'(1);
      end
      read_entry = rd_row_ff[cmd_ff.way];
   end

   always_comb begin
      state_in      = state_ff;
      clear_addr_in = clear_addr_ff;
      cmd_in        = cmd_ff;
      pop           = 1'b0;
      rd_en         = 1'b0;
      rd_addr       = q_status.head.bucket;
      wr_en         = 1'b0;
      wr_addr       = cmd_ff.bucket;
      wr_row        = rd_row_ff;
      out_valid_in  = out_valid_ff && !rsp_bus.ready;
      out_in        = out_ff;
      unique case (state_ff)
         BK_CLEAR: begin
            wr_en         = 1'b1;
            wr_addr       = clear_addr_ff;
            wr_row        = '0;
            clear_addr_in = clear_addr_ff + bucket_type'(1);
            if (clear_addr_ff == bucket_type'(SLOTS - 1)) begin
               state_in = BK_IDLE;
            end
         end
         BK_IDLE: begin
            if (!q_status.empty && (!out_valid_ff || rsp_bus.ready)) begin
               pop      = 1'b1;
               rd_en    = 1'b1;
               cmd_in   = q_status.head;
               state_in = BK_LOOKUP;
            end
         end
         BK_LOOKUP: begin
            out_valid_in       = 1'b1;
            out_in             = '0;
            out_in.total_pairs = cmd_ff.total;
            state_in           = BK_IDLE;
            if (cmd_ff.opcode == OP_READ) begin
               if (read_entry.valid) begin
                  out_in.entry_valid = 1'b1;
                  out_in.first_char  = read_entry.first_char;
                  out_in.second_char = read_entry.second_char;
                  out_in.pair_count  = read_entry.count;
               end
            end else begin
               out_in.is_delimiter = cmd_ff.is_delimiter;
               if (cmd_ff.pair_formed) begin
                  out_in.pair_formed = 1'b1;
                  out_in.first_char  = cmd_ff.first_char;
                  out_in.second_char = cmd_ff.second_char;
                  priority if (hit_found) begin
                     wr_en                   = 1'b1;
                     wr_row[hit_way].count   = hit_count;
                     out_in.pair_count       = hit_count;
                  end else if (free_found) begin
                     wr_en                        = 1'b1;
                     wr_row[free_way].valid       = 1'b1;
                     wr_row[free_way].first_char  = cmd_ff.first_char;
                     wr_row[free_way].second_char = cmd_ff.second_char;
                     wr_row[free_way].count       = count_type'(1);
                     out_in.pair_count            = count_type'(1);
                  end else begin
                     out_in.dropped = 1'b1;
                  end
               end
            end
         end
         default: begin
            state_in = BK_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         row_mem[wr_addr] <= wr_row;
      end
      if (rd_en) begin
         rd_row_ff <= row_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= BK_CLEAR;
         clear_addr_ff <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clear_addr_ff <= clear_addr_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
      out_ff <= out_in;
   end

   assign clear_done           = (state_ff != BK_CLEAR);
   assign rsp_bus.valid        = out_valid_ff;
   assign rsp_bus.pair_formed  = out_ff.pair_formed;
   assign rsp_bus.is_delimiter = out_ff.is_delimiter;
   assign rsp_bus.dropped      = out_ff.dropped;
   assign rsp_bus.entry_valid  = out_ff.entry_valid;
   assign rsp_bus.first_char   = out_ff.first_char;
   assign rsp_bus.second_char  = out_ff.second_char;
   assign rsp_bus.pair_count   = out_ff.pair_count;
   assign rsp_bus.total_pairs  = out_ff.total_pairs;

endmodule

`default_nettype wire

FILE: rtl/core/bigram_hash_counter.sv
// ----------------------------------------------------------------------------
// bigram_hash_counter
// Counts bigrams of adjacent non-delimiter characters in a 4096-bucket,
// four-way hash table, with a read-back operation for single entries.
//
//   Channel   Direction   Carries
//   req_bus   in          opcode, char_code, read_bucket, read_way
//   rsp_bus   out         pair_formed .. total_pairs, one per request
//
// In the table engine each transaction first reads the bucket row from the
// single memory, then compares its ways and writes the row back.
// After reset the engine clears all 4096 rows of the memory one row a cycle,
// with req_bus.ready held low. A two-entry queue decouples the front end, so
// requests are taken until the queue fills while a response waits on a stalled rsp_bus.
// ----------------------------------------------------------------------------
`default_nettype none

module bigram_hash_counter import bhc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   bhc_req_if.sink    req_bus,
   bhc_rsp_if.source  rsp_bus
);

   logic             push;
   cmd_type          push_cmd;
   logic             pop;
   logic             clear_done;
   queue_status_type q_status;

   bhc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .clear_done (clear_done),
      .q_status   (q_status),
      .push       (push),
      .push_cmd   (push_cmd)
   );

   bhc_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .q_status (q_status)
   );

   bhc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_status   (q_status),
      .pop        (pop),
      .clear_done (clear_done),
      .rsp_bus    (rsp_bus)
   );

endmodule

`default_nettype wire
